// ----- sv/sound_cpu_bus_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Sound CPU bus decoder assertion macros
// Small wrappers that keep the concurrent checks in the decoder short.
// ----------------------------------------------------------------------------
`ifndef SOUND_CPU_BUS_DECODER_ASSERT_SVH
`define SOUND_CPU_BUS_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SCBD_ASSERT_NOW(label, ck, rst_n, cond, impl, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (cond) |-> (impl)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SCBD_ASSERT_NEXT(label, ck, rst_n, cond, impl, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (cond) |=> (impl)) \
		else $error(msg);

`endif

// ----- sv/scbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Sound CPU bus decoder package
// Operation, route and command codes, address map constants and the
// structures that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package scbd_pkg;

	// Access codes on the operation input.
	typedef enum logic [1:0] {
		OP_MAIN_RD  = 2'd0,
		OP_MAIN_WR  = 2'd1,
		OP_SOUND_RD = 2'd2,
		OP_SOUND_WR = 2'd3
	} scbd_op_t;

	// Codes on the route output.
	typedef enum logic [2:0] {
		ROUTE_LOCAL    = 3'd0,
		ROUTE_CHIP_RD  = 3'd1,
		ROUTE_CHIP_WR  = 3'd2,
		ROUTE_TONE_WR  = 3'd3,
		ROUTE_BUS_RD   = 3'd4,
		ROUTE_BUS_WR   = 3'd5
	} scbd_route_t;

	// What the back end has to do with a classified word.
	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_RAM_RD    = 3'd1,
		CMD_RAM_WR    = 3'd2,
		CMD_STATUS_RD = 3'd3,
		CMD_GRANT_WR  = 3'd4,
		CMD_HOLD_WR   = 3'd5,
		CMD_BANK_WR   = 3'd6,
		CMD_PASS      = 3'd7
	} scbd_kind_t;

	// Main-side address map.
	localparam logic [23:0] MAIN_RAM_BASE = 24'hA00000;
	localparam logic [23:0] MAIN_BUSREQ   = 24'hA11100;
	localparam logic [23:0] MAIN_RESET    = 24'hA11200;
	localparam logic [23:0] REGION_MASK   = 24'hFF0000;
	localparam logic [23:0] PAGE_MASK     = 24'hFFFF00;

	// Sound-side address map.
	localparam logic [15:0] SOUND_CHIP_BASE = 16'h4000;
	localparam logic [15:0] SOUND_BANK_BASE = 16'h6000;
	localparam logic [15:0] SOUND_BANK_END  = 16'h6100;
	localparam logic [15:0] SOUND_TONE_ADDR = 16'h7F11;
	localparam logic [15:0] SOUND_WINDOW    = 16'h8000;

	localparam int BANK_W      = 9;
	localparam int WINDOW_W    = 15;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	// One classified word as it sits in the queue.
	typedef struct packed {
		scbd_kind_t          kind;
		scbd_route_t         route;
		logic [WINDOW_W-1:0] addr;
		logic [7:0]          data;
	} scbd_cmd_t;

	// Queue fill status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} scbd_queue_status_t;

	// Back end status seen by the queue and the front end.
	typedef struct packed {
		logic clearing;
		logic pop;
	} scbd_back_status_t;

endpackage

`default_nettype wire

// ----- sv/sound_cpu_bus_decoder.sv -----
// ----------------------------------------------------------------------------
// Sound CPU bus decoder
// Memory map of the sound sub-system as seen from the main CPU and the sound
// CPU: shared RAM, bus request and reset flags, bank window and pass-through.
// ----------------------------------------------------------------------------
// Every accepted word produces exactly one result word, in order. The block
// sustains one word per clock while neither side stalls and the RAM is not
// being cleared: the back end does one access to its single-port RAM or one
// flag or bank update per cycle, and that RAM port is what sets the rate. A
// word passes three registers (front register, queue, result register); the
// front register loads at the accepting edge itself. A four-entry queue lets
// the two sides stall independently, and a new word is taken while a finished
// result still waits. After reset the shared RAM is swept to zero, one byte
// per cycle, and in_stall stays high until the sweep ends, before the first
// word is accepted. Forwarded reads (sound chip status, main bus) return 0
// here; outside logic supplies the real value.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sound_cpu_bus_decoder_assert.svh"

module sound_cpu_bus_decoder #(
	parameter int RAM_BYTES = 8192
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [23:0] address,
	input  wire  [7:0]  write_data,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  read_data,
	output logic [2:0]  route,
	output logic [23:0] forward_address,
	output logic [7:0]  forward_data,
	output logic        sound_cpu_running,
	output logic        reset_pulse
);

	localparam int IDX_W = $clog2(RAM_BYTES);

	scbd_pkg::scbd_queue_status_t q_status;
	scbd_pkg::scbd_back_status_t  b_status;
	scbd_pkg::scbd_cmd_t          front_cmd;
	scbd_pkg::scbd_cmd_t          head_cmd;
	logic [IDX_W-1:0]             front_idx;
	logic [IDX_W-1:0]             head_idx;
	logic                         push;

	// The front end takes words, folds the address into the RAM and decides
	// what kind of access it is; the classification is independent of state.
	scbd_front #(
		.RAM_BYTES(RAM_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.address   (address),
		.write_data(write_data),
		.q_status  (q_status),
		.b_status  (b_status),
		.push      (push),
		.cmd       (front_cmd),
		.idx       (front_idx)
	);

	// Classified words wait here until the back end can execute them.
	scbd_queue #(
		.RAM_BYTES(RAM_BYTES)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(front_cmd),
		.push_idx(front_idx),
		.b_status(b_status),
		.q_status(q_status),
		.head_cmd(head_cmd),
		.head_idx(head_idx)
	);

	// The back end executes words in order against the RAM, the flags and
	// the bank register, so every access sees the effect of all before it.
	scbd_back #(
		.RAM_BYTES(RAM_BYTES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_status         (q_status),
		.head_cmd         (head_cmd),
		.head_idx         (head_idx),
		.b_status         (b_status),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_data        (read_data),
		.route            (route),
		.forward_address  (forward_address),
		.forward_data     (forward_data),
		.sound_cpu_running(sound_cpu_running),
		.reset_pulse      (reset_pulse)
	);

	// No word may enter while the RAM is being swept.
	`SCBD_ASSERT_NOW(a_stall_while_clearing, clk, arst_n, b_status.clearing, in_stall,
		"word accepted during RAM clear")
	// A word taken from the queue is offered at the output in the next cycle.
	`SCBD_ASSERT_NEXT(a_pop_gives_result, clk, arst_n, b_status.pop, out_valid,
		"executed word produced no result")
	// Only local accesses carry read data back.
	`SCBD_ASSERT_NOW(a_forward_reads_zero, clk, arst_n,
		out_valid && (route != scbd_pkg::ROUTE_LOCAL), read_data == 8'd0,
		"forwarded access returned data")
	// A reset pulse means reset is now held, so the sound CPU cannot run.
	`SCBD_ASSERT_NOW(a_pulse_stops_cpu, clk, arst_n, out_valid && reset_pulse,
		!sound_cpu_running, "reset pulse with sound CPU running")

endmodule

`default_nettype wire

// ----- sv/scbd_front.sv -----
// ----------------------------------------------------------------------------
// Sound CPU bus decoder front end
// Accepts words, reduces the address to a RAM index and classifies the access.
// ----------------------------------------------------------------------------
`default_nettype none

module scbd_front #(
	parameter int RAM_BYTES = 8192
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [1:0]                       operation,
	input  wire  [23:0]                      address,
	input  wire  [7:0]                       write_data,
	input  scbd_pkg::scbd_queue_status_t     q_status,
	input  scbd_pkg::scbd_back_status_t      b_status,
	output logic                             push,
	output scbd_pkg::scbd_cmd_t              cmd,
	output logic [$clog2(RAM_BYTES)-1:0]     idx
);

	localparam int IDX_W = $clog2(RAM_BYTES);
	localparam int RECIP = 65536 / RAM_BYTES;
	localparam int MW    = $clog2(RECIP + 1);
	localparam int PW    = 16 + MW;
	localparam logic [16:0] N_EXT = 17'(RAM_BYTES);

	logic                  v_s1;
	scbd_pkg::scbd_op_t    op_s1;
	logic [23:0]           addr_s1;
	logic [7:0]            data_s1;
	logic [MW-1:0]         quot_s1;

	logic [PW-1:0]         prod;
	logic [16:0]           qn;
	logic [16:0]           rem_raw;
	logic [16:0]           rem_fix;
	logic                  take;
	logic [15:0]           a16;
	logic                  wr;

	// Estimated quotient is low by at most one; the remainder is fixed below.
	assign prod = PW'(address[15:0]) * PW'(RECIP);

	assign take     = in_valid && !in_stall;
	assign in_stall = b_status.clearing || (v_s1 && q_status.full);
	assign push     = v_s1 && !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= scbd_pkg::scbd_op_t'(operation);
			addr_s1 <= address;
			data_s1 <= write_data;
			quot_s1 <= prod[PW-1:16];
		end
	end

	assign qn      = 17'(quot_s1) * N_EXT;
	assign rem_raw = {1'b0, addr_s1[15:0]} - qn;
	assign rem_fix = (rem_raw >= N_EXT) ? (rem_raw - N_EXT) : rem_raw;
	assign idx     = rem_fix[IDX_W-1:0];

	assign a16 = addr_s1[15:0];
	assign wr  = (op_s1 == scbd_pkg::OP_SOUND_WR);

	always_comb begin
		cmd.kind  = scbd_pkg::CMD_NONE;
		cmd.route = scbd_pkg::ROUTE_LOCAL;
		cmd.addr  = addr_s1[scbd_pkg::WINDOW_W-1:0];
		cmd.data  = 8'd0;
		case (op_s1)
			scbd_pkg::OP_MAIN_RD: begin
				if ((addr_s1 & scbd_pkg::REGION_MASK) == scbd_pkg::MAIN_RAM_BASE) begin
					cmd.kind = scbd_pkg::CMD_RAM_RD;
				end else if ((addr_s1 & scbd_pkg::PAGE_MASK) == scbd_pkg::MAIN_BUSREQ) begin
					cmd.kind = scbd_pkg::CMD_STATUS_RD;
				end
			end
			scbd_pkg::OP_MAIN_WR: begin
				cmd.data = data_s1;
				if ((addr_s1 & scbd_pkg::REGION_MASK) == scbd_pkg::MAIN_RAM_BASE) begin
					cmd.kind = scbd_pkg::CMD_RAM_WR;
				end else if (!addr_s1[0]) begin
					if ((addr_s1 & scbd_pkg::PAGE_MASK) == scbd_pkg::MAIN_BUSREQ) begin
						cmd.kind = scbd_pkg::CMD_GRANT_WR;
					end else if ((addr_s1 & scbd_pkg::PAGE_MASK) == scbd_pkg::MAIN_RESET) begin
						cmd.kind = scbd_pkg::CMD_HOLD_WR;
					end
				end
			end
			scbd_pkg::OP_SOUND_RD, scbd_pkg::OP_SOUND_WR: begin
				if (a16 < scbd_pkg::SOUND_CHIP_BASE) begin
					cmd.kind = wr ? scbd_pkg::CMD_RAM_WR : scbd_pkg::CMD_RAM_RD;
					cmd.data = data_s1;
				end else if (a16 < scbd_pkg::SOUND_BANK_BASE) begin
					cmd.kind  = scbd_pkg::CMD_PASS;
					cmd.route = wr ? scbd_pkg::ROUTE_CHIP_WR : scbd_pkg::ROUTE_CHIP_RD;
					cmd.data  = wr ? data_s1 : 8'd0;
				end else if (a16 < scbd_pkg::SOUND_WINDOW) begin
					if (wr) begin
						if (a16 < scbd_pkg::SOUND_BANK_END) begin
							cmd.kind = scbd_pkg::CMD_BANK_WR;
							cmd.data = data_s1;
						end else if (a16 == scbd_pkg::SOUND_TONE_ADDR) begin
							cmd.kind  = scbd_pkg::CMD_PASS;
							cmd.route = scbd_pkg::ROUTE_TONE_WR;
							cmd.data  = data_s1;
						end
					end
				end else begin
					cmd.kind  = scbd_pkg::CMD_PASS;
					cmd.route = wr ? scbd_pkg::ROUTE_BUS_WR : scbd_pkg::ROUTE_BUS_RD;
					cmd.data  = wr ? data_s1 : 8'd0;
				end
			end
			default: begin
				cmd.kind = scbd_pkg::CMD_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/scbd_queue.sv -----
// ----------------------------------------------------------------------------
// Sound CPU bus decoder command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scbd_queue #(
	parameter int RAM_BYTES = 8192
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              push,
	input  scbd_pkg::scbd_cmd_t              push_cmd,
	input  wire  [$clog2(RAM_BYTES)-1:0]     push_idx,
	input  scbd_pkg::scbd_back_status_t      b_status,
	output scbd_pkg::scbd_queue_status_t     q_status,
	output scbd_pkg::scbd_cmd_t              head_cmd,
	output logic [$clog2(RAM_BYTES)-1:0]     head_idx
);

	localparam int IDX_W = $clog2(RAM_BYTES);

	scbd_pkg::scbd_cmd_t                 cmd_q [scbd_pkg::QUEUE_DEPTH];
	logic [IDX_W-1:0]                    idx_q [scbd_pkg::QUEUE_DEPTH];
	logic [scbd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [scbd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [scbd_pkg::QUEUE_CNT_W-1:0]    count_q;

	assign q_status.full  = (count_q == scbd_pkg::QUEUE_CNT_W'(scbd_pkg::QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_cmd       = cmd_q[rd_ptr_q];
	assign head_idx       = idx_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (b_status.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !b_status.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && b_status.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= push_cmd;
			idx_q[wr_ptr_q] <= push_idx;
		end
	end

endmodule

`default_nettype wire

// ----- sv/scbd_back.sv -----
// ----------------------------------------------------------------------------
// Sound CPU bus decoder back end
// Owns the shared RAM, the flags and the bank register, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module scbd_back #(
	parameter int RAM_BYTES = 8192
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  scbd_pkg::scbd_queue_status_t     q_status,
	input  scbd_pkg::scbd_cmd_t              head_cmd,
	input  wire  [$clog2(RAM_BYTES)-1:0]     head_idx,
	output scbd_pkg::scbd_back_status_t      b_status,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [7:0]                       read_data,
	output logic [2:0]                       route,
	output logic [23:0]                      forward_address,
	output logic [7:0]                       forward_data,
	output logic                             sound_cpu_running,
	output logic                             reset_pulse
);

	localparam int IDX_W = $clog2(RAM_BYTES);

	logic [7:0]                    mem_q [RAM_BYTES];
	logic [IDX_W-1:0]              clr_q;
	logic                          clearing_q;
	logic [scbd_pkg::BANK_W-1:0]   bank_q;
	logic                          granted_q;
	logic                          held_q;
	logic                          out_valid_q;

	scbd_pkg::scbd_route_t         route_q;
	logic [23:0]                   fa_q;
	logic [7:0]                    fd_q;
	logic [7:0]                    rd_q;
	logic                          use_ram_q;
	logic                          running_q;
	logic                          pulse_q;
	logic [7:0]                    ram_rd_q;

	logic                          pop;
	logic [scbd_pkg::BANK_W-1:0]   bank_nx;
	logic                          granted_nx;
	logic                          held_nx;
	logic                          pulse_nx;
	logic [7:0]                    rd_nx;
	logic                          use_ram_nx;
	logic [23:0]                   fa_nx;

	// A word leaves the queue only when the result register is free or drains now.
	assign pop = !clearing_q && !q_status.empty && (!out_valid_q || !out_stall);

	assign b_status.clearing = clearing_q;
	assign b_status.pop      = pop;

	always_comb begin
		bank_nx    = bank_q;
		granted_nx = granted_q;
		held_nx    = held_q;
		pulse_nx   = 1'b0;
		rd_nx      = 8'd0;
		use_ram_nx = 1'b0;
		case (head_cmd.kind)
			scbd_pkg::CMD_RAM_RD: begin
				use_ram_nx = 1'b1;
			end
			scbd_pkg::CMD_STATUS_RD: begin
				rd_nx = {7'd0, !granted_q};
			end
			scbd_pkg::CMD_GRANT_WR: begin
				granted_nx = head_cmd.data[0];
			end
			scbd_pkg::CMD_HOLD_WR: begin
				held_nx  = !head_cmd.data[0];
				pulse_nx = !head_cmd.data[0];
			end
			scbd_pkg::CMD_BANK_WR: begin
				bank_nx = {head_cmd.data[0], bank_q[scbd_pkg::BANK_W-1:1]};
			end
			default: begin
				pulse_nx = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (head_cmd.route)
			scbd_pkg::ROUTE_BUS_RD, scbd_pkg::ROUTE_BUS_WR: begin
				fa_nx = {bank_q, head_cmd.addr};
			end
			scbd_pkg::ROUTE_CHIP_RD, scbd_pkg::ROUTE_CHIP_WR: begin
				fa_nx = {22'd0, head_cmd.addr[1:0]};
			end
			default: begin
				fa_nx = 24'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			bank_q      <= '0;
			granted_q   <= 1'b1;
			held_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == IDX_W'(RAM_BYTES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (pop) begin
				bank_q      <= bank_nx;
				granted_q   <= granted_nx;
				held_q      <= held_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			route_q   <= head_cmd.route;
			fa_q      <= fa_nx;
			fd_q      <= head_cmd.data & {8{head_cmd.kind == scbd_pkg::CMD_PASS}};
			rd_q      <= rd_nx;
			use_ram_q <= use_ram_nx;
			running_q <= !granted_nx && !held_nx;
			pulse_q   <= pulse_nx;
		end
	end

	// Single-port RAM: the clearing sweep or one word's access per cycle.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_q] <= 8'd0;
		end else if (pop && head_cmd.kind == scbd_pkg::CMD_RAM_WR) begin
			mem_q[head_idx] <= head_cmd.data;
		end
		if (pop && head_cmd.kind == scbd_pkg::CMD_RAM_RD) begin
			ram_rd_q <= mem_q[head_idx];
		end
	end

	assign out_valid         = out_valid_q;
	assign read_data         = use_ram_q ? ram_rd_q : rd_q;
	assign route             = route_q;
	assign forward_address   = fa_q;
	assign forward_data      = fd_q;
	assign sound_cpu_running = running_q;
	assign reset_pulse       = pulse_q;

endmodule

`default_nettype wire
